// ===== src/assert_macros.svh =====
// assertion helpers included by the carving block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, masked while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/vcdm_pkg.sv =====
// ----------------------------------------------------------------------------
// vcdm_pkg
// Codes, field widths and defaults for the six-view depth carving block.
// ----------------------------------------------------------------------------
package vcdm_pkg;

    localparam int MAX_DIM_DEF         = 64;
    localparam int DEPTH_FRAC_BITS_DEF = 16;

    localparam int FUNC_W  = 2;
    localparam int FACE_W  = 3;
    localparam int COORD_W = 6;
    localparam int DEPTH_W = 17;
    localparam int GRID_W  = 7;
    localparam int LEN_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_FILL  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CARVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
    localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

endpackage

// ===== src/voxel_carve_by_depth_maps.sv =====
// ----------------------------------------------------------------------------
// voxel_carve_by_depth_maps
// One-bit occupancy grid carved by six orthographic depth views.
// ----------------------------------------------------------------------------
// steps: read fetches the row, picks the bit; carve sets the run length len (up to
//   MAX_DIM), clears one voxel a step; fill reruns the sweep; unknown func goes
//   to the result; throughput: one item at a time, the next taken once the result is
//   registered; the grid memory clears one voxel or fills one row of MAX_DIM voxels
//   a cycle. reset: synchronous active low; afterwards a sweep sets every row of the
//   grid to occupied, with s_ready low meanwhile
module voxel_carve_by_depth_maps
    import vcdm_pkg::*;
#(
    parameter int MAX_DIM         = MAX_DIM_DEF,
    parameter int DEPTH_FRAC_BITS = DEPTH_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GRID_W-1:0]    cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FUNC_W-1:0]    s_func,
    input  logic [FACE_W-1:0]    s_face,
    input  logic [COORD_W-1:0]   s_pix_u,
    input  logic [COORD_W-1:0]   s_pix_v,
    input  logic [DEPTH_W-1:0]   s_depth,
    input  logic [COORD_W-1:0]   s_vox_x,
    input  logic [COORD_W-1:0]   s_vox_y,
    input  logic [COORD_W-1:0]   s_vox_z,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_occupied,
    output logic [LEN_W-1:0]     m_carved_len
);

`include "assert_macros.svh"

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = (DIM_W > GRID_W) ? DIM_W : GRID_W;
    localparam int PW    = DEPTH_W + DIM_W;
    localparam int RAW   = 2 * AW;
    localparam int ROWS  = 1 << RAW;

    typedef enum logic [2:0] {
        ST_SWEEP, ST_IDLE, ST_MUL, ST_LEN, ST_CARVE, ST_RD, ST_RDW, ST_OUT
    } state_t;

    state_t state_reg;

    logic [GRID_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;

    logic [FACE_W-1:0]  face_reg;
    logic [COORD_W-1:0] u_reg, v_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COORD_W-1:0] rx_reg, ry_reg, rz_reg;

    logic              fill_item_reg;
    logic [RAW-1:0]    sweep_cnt_reg;
    logic [PW-1:0]     prod_reg;
    logic [DIM_W-1:0]  n_reg;
    logic              ok_reg;
    logic [DIM_W-1:0]  len_reg;
    logic [DIM_W-1:0]  cnt_reg;
    logic              occ_reg;

    logic              m_valid_reg;
    logic              m_occupied_reg;
    logic [LEN_W-1:0]  m_carved_len_reg;

    // grid memory: row = {z, y}, bit = x
    logic [MAX_DIM-1:0] grid_mem [ROWS];
    logic [MAX_DIM-1:0] rd_row_reg;

    logic               wr_en;
    logic [RAW-1:0]     wr_addr;
    logic [MAX_DIM-1:0] wr_mask;
    logic [MAX_DIM-1:0] wr_data;

    logic [DIM_W-1:0] nx, ny, nz;
    logic [DIM_W-1:0] sel_n, lim_u, lim_v;
    logic             face_ok;
    logic [AW-1:0]    cx, cy, cz;
    logic [PW-1:0]    len_raw;
    logic [DIM_W-1:0] len_sat;
    logic             rd_in_range;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [GRID_W-1:0] r);
        logic [DIM_W-1:0] res;
        if (r == '0) begin
            res = DIM_W'(1);
        end else if (CW'(r) > CW'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(r);
        end
        return res;
    endfunction

    assign nx = eff_dim(grid_x_reg);
    assign ny = eff_dim(grid_y_reg);
    assign nz = eff_dim(grid_z_reg);

    // axis length and pixel limits for the view
    always_comb begin
        sel_n   = nx;
        lim_u   = ny;
        lim_v   = nz;
        face_ok = 1'b1;
        case (face_reg)
            FACE_PX, FACE_NX: begin
                sel_n = nx; lim_u = ny; lim_v = nz;
            end
            FACE_PY, FACE_NY: begin
                sel_n = ny; lim_u = nx; lim_v = nz;
            end
            FACE_PZ, FACE_NZ: begin
                sel_n = nz; lim_u = nx; lim_v = ny;
            end
            default: begin
                face_ok = 1'b0;
            end
        endcase
    end

    assign len_raw = prod_reg >> DEPTH_FRAC_BITS;
    assign len_sat = (len_raw > PW'(n_reg)) ? n_reg : DIM_W'(len_raw);

    // voxel hit by the current carve step
    always_comb begin
        cx = AW'(u_reg);
        cy = AW'(v_reg);
        cz = AW'(cnt_reg);
        case (face_reg)
            FACE_PX: begin
                cx = AW'(nx - DIM_W'(1) - cnt_reg);
                cy = AW'(u_reg);
                cz = AW'(v_reg);
            end
            FACE_NX: begin
                cx = AW'(cnt_reg);
                cy = AW'(u_reg);
                cz = AW'(nz - DIM_W'(1) - DIM_W'(v_reg));
            end
            FACE_PY: begin
                cx = AW'(u_reg);
                cy = AW'(ny - DIM_W'(1) - cnt_reg);
                cz = AW'(nz - DIM_W'(1) - DIM_W'(v_reg));
            end
            FACE_NY: begin
                cx = AW'(u_reg);
                cy = AW'(cnt_reg);
                cz = AW'(v_reg);
            end
            FACE_PZ: begin
                cx = AW'(u_reg);
                cy = AW'(v_reg);
                cz = AW'(nz - DIM_W'(1) - cnt_reg);
            end
            default: begin
                cx = AW'(u_reg);
                cy = AW'(ny - DIM_W'(1) - DIM_W'(v_reg));
                cz = AW'(cnt_reg);
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_cnt_reg;
        wr_mask = '1;
        wr_data = '1;
        case (state_reg)
            ST_SWEEP: begin
                wr_en = 1'b1;
            end
            ST_CARVE: begin
                wr_en   = 1'b1;
                wr_addr = {cz, cy};
                wr_mask = MAX_DIM'(1) << cx;
                wr_data = '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < MAX_DIM; b++) begin
                if (wr_mask[b]) begin
                    grid_mem[wr_addr][b] <= wr_data[b];
                end
            end
        end
        rd_row_reg <= grid_mem[{AW'(rz_reg), AW'(ry_reg)}];
    end

    assign rd_in_range = (CW'(rx_reg) < CW'(nx)) && (CW'(ry_reg) < CW'(ny))
                      && (CW'(rz_reg) < CW'(nz));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            fill_item_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            grid_x_reg    <= GRID_RESET;
            grid_y_reg    <= GRID_RESET;
            grid_z_reg    <= GRID_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRID_X: grid_x_reg <= cfg_data;
                    REG_GRID_Y: grid_y_reg <= cfg_data;
                    REG_GRID_Z: grid_z_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end

            // in ST_OUT the result register is loaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SWEEP: begin
                    sweep_cnt_reg <= RAW'(sweep_cnt_reg + 1'b1);
                    if (sweep_cnt_reg == RAW'(ROWS - 1)) begin
                        fill_item_reg <= 1'b0;
                        state_reg     <= fill_item_reg ? ST_OUT : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        face_reg  <= s_face;
                        u_reg     <= s_pix_u;
                        v_reg     <= s_pix_v;
                        depth_reg <= s_depth;
                        rx_reg    <= s_vox_x;
                        ry_reg    <= s_vox_y;
                        rz_reg    <= s_vox_z;
                        len_reg   <= '0;
                        occ_reg   <= 1'b0;
                        case (s_func)
                            FUNC_FILL: begin
                                fill_item_reg <= 1'b1;
                                sweep_cnt_reg <= '0;
                                state_reg     <= ST_SWEEP;
                            end
                            FUNC_CARVE: state_reg <= ST_MUL;
                            FUNC_READ:  state_reg <= ST_RD;
                            default:    state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PW'(depth_reg) * PW'(sel_n);
                    n_reg     <= sel_n;
                    ok_reg    <= face_ok && (CW'(u_reg) < CW'(lim_u))
                                 && (CW'(v_reg) < CW'(lim_v));
                    state_reg <= ST_LEN;
                end
                ST_LEN: begin
                    cnt_reg <= '0;
                    if (ok_reg && len_sat != '0) begin
                        len_reg   <= len_sat;
                        state_reg <= ST_CARVE;
                    end else begin
                        len_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_CARVE: begin
                    cnt_reg <= DIM_W'(cnt_reg + 1'b1);
                    if (DIM_W'(cnt_reg + 1'b1) == len_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_RD: begin
                    // row read issued this cycle
                    state_reg <= ST_RDW;
                end
                ST_RDW: begin
                    occ_reg   <= rd_in_range & rd_row_reg[AW'(rx_reg)];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg      <= 1'b1;
                        m_occupied_reg   <= occ_reg;
                        m_carved_len_reg <= LEN_W'(len_reg);
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_occupied   = m_occupied_reg;
    assign m_carved_len = m_carved_len_reg;

    `ASSERT_CLK(a_carve_step_in_run, aclk, aresetn,
        (state_reg == ST_CARVE) |-> (cnt_reg < len_reg), "carve step beyond run length")
    `ASSERT_CLK(a_one_item_at_a_time, aclk, aresetn,
        (s_valid && s_ready) |=> !s_ready, "second item taken while one is at work")
    `ASSERT_CLK(a_result_kinds_exclusive, aclk, aresetn,
        m_valid |-> !(m_occupied && (m_carved_len != '0)), "result reports both a read and a carve")
    `ASSERT_CLK_ALWAYS(a_reset_clears_output, aclk,
        !aresetn |=> !m_valid, "result valid right after reset")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Directed and random test of the six-view depth carving block. Items are
// checked against their table row or a local occupancy grid that follows every
// fill, carve and read; several grid sizes; random gaps, stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import vcdm_pkg::*;

    localparam int GRID_CELLS = MAX_DIM_DEF * MAX_DIM_DEF * MAX_DIM_DEF;

    // codes the block must tolerate but the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [FACE_W-1:0]    FACE_BAD_LO = 3'd6;
    localparam logic [FACE_W-1:0]    FACE_BAD_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FACE_W-1:0]  face;
        logic [COORD_W-1:0] pix_u;
        logic [COORD_W-1:0] pix_v;
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] vox_x;
        logic [COORD_W-1:0] vox_y;
        logic [COORD_W-1:0] vox_z;
    } carve_item_t;

    typedef struct packed {
        logic             occ;
        logic [LEN_W-1:0] len;
    } voxel_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [GRID_W-1:0] gx;
        logic [GRID_W-1:0] gy;
        logic [GRID_W-1:0] gz;
        carve_item_t       it;
        logic              typed;
        voxel_result_t     res;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GRID_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func = '0;
    logic [FACE_W-1:0]    s_face = '0;
    logic [COORD_W-1:0]   s_pix_u = '0;
    logic [COORD_W-1:0]   s_pix_v = '0;
    logic [DEPTH_W-1:0]   s_depth = '0;
    logic [COORD_W-1:0]   s_vox_x = '0;
    logic [COORD_W-1:0]   s_vox_y = '0;
    logic [COORD_W-1:0]   s_vox_z = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_occupied;
    logic [LEN_W-1:0]     m_carved_len;

    bit                occupancy [0:GRID_CELLS-1];
    logic [GRID_W-1:0] grid_reg [3] = '{GRID_RESET, GRID_RESET, GRID_RESET};
    voxel_result_t     pending_voxel_results [$];
    int                errors = 0;
    int                out_stall = 0;
    bit                no_idle = 1'b0;

    // column of the latest carve, so reads can land on carved voxels
    bit                have_last = 1'b0;
    logic [FACE_W-1:0] last_face;
    int                last_u;
    int                last_v;

    directed_row_t directed_rows [28] = '{
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 0, 0, 0}, 1, '{1, 0}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 63, 63, 63}, 1, '{1, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PX, 0, 0, 65536, 0, 0, 0}, 1, '{0, 64}},
        // same column again: the run still counts in full
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PX, 0, 0, 65536, 0, 0, 0}, 1, '{0, 64}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_NX, 63, 63, 0, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PY, 63, 0, 1, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_NY, 5, 6, 1024, 0, 0, 0}, 1, '{0, 1}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 5, 0, 6}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PY, 7, 9, 40000, 0, 0, 0}, 0, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PZ, 10, 20, 131071, 0, 0, 0}, 1, '{0, 64}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_NZ, 63, 63, 32768, 0, 0, 0}, 1, '{0, 32}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 63, 0, 31}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_BAD_LO, 1, 1, 65536, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_BAD_HI, 2, 2, 65536, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_UNUSED, FACE_BAD_HI, 63, 63, 131071, 63, 63, 63}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_FILL, FACE_PX, 0, 0, 0, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 0, 0, 0}, 1, '{1, 0}},
        '{1, 5, 9, 3, '{FUNC_FILL, FACE_PX, 0, 0, 0, 0, 0, 0}, 0, '{0, 0}},
        // pixel outside the grid in use, once on u and once on v
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PX, 9, 0, 65536, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PX, 0, 3, 65536, 0, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 5, 0, 0}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_PZ, 4, 8, 65536, 0, 0, 0}, 1, '{0, 3}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 4, 8, 0}, 1, '{0, 0}},
        // zero acts as one, oversize acts as the full grid
        '{1, 0, 0, 127, '{FUNC_FILL, FACE_PX, 0, 0, 0, 0, 0, 0}, 0, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_CARVE, FACE_NZ, 0, 0, 65536, 0, 0, 0}, 1, '{0, 64}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 0, 0, 63}, 1, '{0, 0}},
        '{0, 0, 0, 0, '{FUNC_READ, FACE_PX, 0, 0, 0, 1, 0, 0}, 1, '{0, 0}}
    };

    logic [GRID_W-1:0] phase_grid [8][3] = '{
        '{64, 64, 64}, '{1, 1, 1}, '{127, 127, 127}, '{65, 2, 64},
        '{3, 64, 1}, '{8, 8, 8}, '{0, 0, 0}, '{64, 64, 64}
    };

    voxel_carve_by_depth_maps i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_face       (s_face),
        .s_pix_u      (s_pix_u),
        .s_pix_v      (s_pix_v),
        .s_depth      (s_depth),
        .s_vox_x      (s_vox_x),
        .s_vox_y      (s_vox_y),
        .s_vox_z      (s_vox_z),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_occupied   (m_occupied),
        .m_carved_len (m_carved_len)
    );

    always #4 aclk = ~aclk;

    function automatic int eff_dim(input logic [GRID_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(r);
    endfunction

    function automatic int cell_index(input int x, input int y, input int z);
        return (z * MAX_DIM_DEF + y) * MAX_DIM_DEF + x;
    endfunction

    // run axis size and pixel bounds seen from one face
    function automatic void face_span(input logic [FACE_W-1:0] face,
                                      input int nx, input int ny, input int nz,
                                      output int n, output int lim_u, output int lim_v);
        if (face == FACE_PX || face == FACE_NX) begin
            n = nx; lim_u = ny; lim_v = nz;
        end else if (face == FACE_PY || face == FACE_NY) begin
            n = ny; lim_u = nx; lim_v = nz;
        end else begin
            n = nz; lim_u = nx; lim_v = ny;
        end
    endfunction

    // voxel hit by step id of a run entering from the given face
    function automatic void carve_target(input logic [FACE_W-1:0] face,
                                         input int u, input int v, input int id,
                                         input int nx, input int ny, input int nz,
                                         output int x, output int y, output int z);
        case (face)
            FACE_PX: begin x = nx - 1 - id; y = u;          z = v;           end
            FACE_NX: begin x = id;          y = u;          z = nz - 1 - v;  end
            FACE_PY: begin x = u;           y = ny - 1 - id; z = nz - 1 - v; end
            FACE_NY: begin x = u;           y = id;         z = v;           end
            FACE_PZ: begin x = u;           y = v;          z = nz - 1 - id; end
            default: begin x = u;           y = ny - 1 - v; z = id;          end
        endcase
    endfunction

    function automatic voxel_result_t apply_carve_item(input carve_item_t it);
        voxel_result_t res;
        int nx, ny, nz, n, lim_u, lim_v, run, x, y, z;
        res = '0;
        nx = eff_dim(grid_reg[0]);
        ny = eff_dim(grid_reg[1]);
        nz = eff_dim(grid_reg[2]);
        if (it.func == FUNC_FILL) begin
            foreach (occupancy[i]) occupancy[i] = 1'b1;
        end else if (it.func == FUNC_CARVE && it.face <= FACE_NZ) begin
            face_span(it.face, nx, ny, nz, n, lim_u, lim_v);
            if (int'(it.pix_u) < lim_u && int'(it.pix_v) < lim_v) begin
                run = (int'(it.depth) * n) >> DEPTH_FRAC_BITS_DEF;
                if (run > n) run = n;
                for (int id = 0; id < run; id++) begin
                    carve_target(it.face, int'(it.pix_u), int'(it.pix_v), id,
                                 nx, ny, nz, x, y, z);
                    occupancy[cell_index(x, y, z)] = 1'b0;
                end
                res.len = LEN_W'(run);
            end
        end else if (it.func == FUNC_READ) begin
            if (int'(it.vox_x) < nx && int'(it.vox_y) < ny && int'(it.vox_z) < nz)
                res.occ = occupancy[cell_index(int'(it.vox_x), int'(it.vox_y),
                                               int'(it.vox_z))];
        end
        return res;
    endfunction

    task automatic push_item(input carve_item_t it, input bit typed,
                             input voxel_result_t typed_res);
        int gap;
        voxel_result_t res;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= it.func;
        s_face  <= it.face;
        s_pix_u <= it.pix_u;
        s_pix_v <= it.pix_v;
        s_depth <= it.depth;
        s_vox_x <= it.vox_x;
        s_vox_y <= it.vox_y;
        s_vox_z <= it.vox_z;
        do @(posedge aclk); while (!s_ready);
        res = apply_carve_item(it);
        pending_voxel_results.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GRID_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_GRID_X: grid_reg[0] = val;
            REG_GRID_Y: grid_reg[1] = val;
            REG_GRID_Z: grid_reg[2] = val;
            default: ;
        endcase
    endtask

    // only with the block idle: every result back first
    task automatic set_grid(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
                            input logic [GRID_W-1:0] gz);
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_voxel_results.size() != 0) @(posedge aclk);
        write_reg(REG_SPARE, GRID_W'($urandom));
        write_reg(REG_GRID_X, gx);
        write_reg(REG_GRID_Y, gy);
        write_reg(REG_GRID_Z, gz);
        @(negedge aclk) cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input int count);
        carve_item_t it;
        int pick, sel, nx, ny, nz, n, lim_u, lim_v, x, y, z;
        nx = eff_dim(grid_reg[0]);
        ny = eff_dim(grid_reg[1]);
        nz = eff_dim(grid_reg[2]);
        for (int k = 0; k < count; k++) begin
            // every field starts random, then the operation shapes it
            it.face  = FACE_W'($urandom);
            it.pix_u = COORD_W'($urandom);
            it.pix_v = COORD_W'($urandom);
            it.depth = DEPTH_W'($urandom_range(0, 131071));
            it.vox_x = COORD_W'($urandom);
            it.vox_y = COORD_W'($urandom);
            it.vox_z = COORD_W'($urandom);
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            if (pick < 2) begin
                it.func = FUNC_FILL;
            end else if (pick < 5) begin
                it.func = FUNC_UNUSED;
            end else if (pick < 52) begin
                it.func = FUNC_CARVE;
                if ($urandom_range(0, 9) != 0) it.face = FACE_W'($urandom_range(0, 5));
                if (it.face <= FACE_NZ) begin
                    face_span(it.face, nx, ny, nz, n, lim_u, lim_v);
                    if ($urandom_range(0, 99) < 85) begin
                        it.pix_u = COORD_W'($urandom_range(0, lim_u - 1));
                        it.pix_v = COORD_W'($urandom_range(0, lim_v - 1));
                    end
                    have_last = 1'b1;
                    last_face = it.face;
                    last_u    = int'(it.pix_u);
                    last_v    = int'(it.pix_v);
                end
                case (sel)
                    0: it.depth = '0;
                    1: it.depth = DEPTH_W'(65536);
                    2: it.depth = DEPTH_W'($urandom_range(65537, 131071));
                    3: it.depth = DEPTH_W'($urandom_range(0, 2047));
                    default: it.depth = DEPTH_W'($urandom_range(0, 65536));
                endcase
            end else begin
                it.func = FUNC_READ;
                if (sel < 5 && have_last) begin
                    face_span(last_face, nx, ny, nz, n, lim_u, lim_v);
                    carve_target(last_face, last_u, last_v, $urandom_range(0, n - 1),
                                 nx, ny, nz, x, y, z);
                    it.vox_x = COORD_W'(x);
                    it.vox_y = COORD_W'(y);
                    it.vox_z = COORD_W'(z);
                end else if (sel < 8) begin
                    it.vox_x = COORD_W'($urandom_range(0, nx < 64 ? nx : 63));
                    it.vox_y = COORD_W'($urandom_range(0, ny < 64 ? ny : 63));
                    it.vox_z = COORD_W'($urandom_range(0, nz < 64 ? nz : 63));
                end
            end
            push_item(it, 1'b0, '0);
        end
    endtask

    // result side: check each item
    always @(posedge aclk) begin : result_check
        voxel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_voxel_results.size() == 0) begin
                $display("%0t: unexpected item, occupied %0d carved_len %0d",
                         $time, m_occupied, m_carved_len);
                errors++;
            end else begin
                want = pending_voxel_results.pop_front();
                if (m_occupied !== want.occ) begin
                    $display("%0t: occupied expected %0d got %0d", $time, want.occ, m_occupied);
                    errors++;
                end
                if (m_carved_len !== want.len) begin
                    $display("%0t: carved_len expected %0d got %0d",
                             $time, want.len, m_carved_len);
                    errors++;
                end
            end
        end
    end

    // stall drawn after each accepted item, applied from the next falling edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                out_stall = no_idle ? 0 : $urandom_range(0, 10);
            @(negedge aclk);
            if (out_stall > 0) begin
                m_ready <= 1'b0;
                out_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        foreach (occupancy[i]) occupancy[i] = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                set_grid(directed_rows[i].gx, directed_rows[i].gy, directed_rows[i].gz);
            else
                push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < 8; p++) begin
            if (p == 5) begin
                phase_grid[p][0] = GRID_W'($urandom_range(1, 8));
                phase_grid[p][1] = GRID_W'($urandom_range(1, 8));
                phase_grid[p][2] = GRID_W'($urandom_range(1, 8));
            end else if (p == 6) begin
                phase_grid[p][0] = GRID_W'($urandom_range(0, 127));
                phase_grid[p][1] = GRID_W'($urandom_range(0, 127));
                phase_grid[p][2] = GRID_W'($urandom_range(0, 127));
            end
            set_grid(phase_grid[p][0], phase_grid[p][1], phase_grid[p][2]);
            no_idle = (p % 3 == 1);
            run_random_phase(200);
        end

        @(negedge aclk) s_valid <= 1'b0;
        while (pending_voxel_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
